/* design/md5_message_digest_defines.svh */
// Assertion helpers for the digest round unit.
`ifndef MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define MD5_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("md5 assertion failed: %m");

// Next-cycle implication, sampled on clk and held off during reset.
`define MD5_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("md5 assertion failed: %m");

`endif

/* design/md5_pkg.sv */
`default_nettype none

package md5_pkg;

	// Initial chaining words.
	localparam logic [31:0] MD5_INIT_A = 32'h67452301;
	localparam logic [31:0] MD5_INIT_B = 32'hEFCDAB89;
	localparam logic [31:0] MD5_INIT_C = 32'h98BADCFE;
	localparam logic [31:0] MD5_INIT_D = 32'h10325476;

	// Padding marker byte and the byte position where the length no longer fits.
	localparam logic [7:0] MD5_PAD_MARK = 8'h80;
	localparam logic [5:0] MD5_LEN_POS  = 6'd56;
	localparam logic [5:0] MD5_LAST_POS = 6'd63;

	// Round constants.
	localparam logic [31:0] MD5_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93ab39,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// Rotate amounts, indexed by {round group, round index mod 4}.
	localparam logic [4:0] MD5_S [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22,
		5'd5, 5'd9,  5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23,
		5'd6, 5'd10, 5'd15, 5'd21
	};

	// One 512-bit block on its way to the round unit.
	typedef struct packed {
		logic             last_blk;
		logic [15:0][31:0] words;
	} md5_blk_t;

	// Front-end sequencer states.
	typedef enum logic [1:0] {
		F_COLLECT,
		F_PAD,
		F_LEN
	} md5_front_state_t;

	// Round-unit sequencer states.
	typedef enum logic [1:0] {
		B_IDLE,
		B_LOAD,
		B_ROUND,
		B_ADD
	} md5_back_state_t;

	// Message word used by a round.
	function automatic logic [3:0] md5_msg_idx(input logic [5:0] r);
		logic [3:0] i;
		logic [3:0] g;
		i = r[3:0];
		case (r[5:4])
			2'd0: g = i;
			2'd1: g = (i << 2) + i + 4'd1;
			2'd2: g = (i << 1) + i + 4'd5;
			2'd3: g = (i << 3) - i;
			default: g = i;
		endcase
		return g;
	endfunction

	// Round function of each group.
	function automatic logic [31:0] md5_f(input logic [1:0] grp, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		case (grp)
			2'd0: f = (b & c) | (~b & d);
			2'd1: f = (d & b) | (~d & c);
			2'd2: f = b ^ c ^ d;
			2'd3: f = c ^ (b | ~d);
			default: f = b ^ c ^ d;
		endcase
		return f;
	endfunction

	// Left rotate.
	function automatic logic [31:0] md5_rotl(input logic [31:0] v, input logic [4:0] s);
		logic [63:0] t;
		t = {v, v} << s;
		return t[63:32];
	endfunction

endpackage

`default_nettype wire

/* design/md5_front.sv */
`default_nettype none

module md5_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [7:0]       data_byte,
	input  wire logic             byte_valid,
	input  wire logic             last,
	input  wire logic             push,
	output logic                  full,
	output logic                  q_push,
	output md5_pkg::md5_blk_t     q_blk,
	input  wire logic             q_full
);

	md5_pkg::md5_front_state_t state_q, state_d;
	logic [63:0]       count_q;
	logic [15:0][31:0] buf_q;
	logic [15:0][31:0] blk_wr;
	logic [15:0][31:0] pad_blk;
	logic [15:0][31:0] len_blk;
	logic [5:0]        pos;
	logic              acc;
	logic              pad_fits;
	logic              cnt_clr;

	assign pos      = count_q[8:3];
	assign pad_fits = pos < md5_pkg::MD5_LEN_POS;
	assign acc      = push && !full;

	// Block with the incoming byte written at its place; a word's first byte clears the word.
	always_comb begin
		blk_wr = buf_q;
		if (pos[1:0] == 2'd0) begin
			blk_wr[pos[5:2]] = {24'd0, data_byte};
		end else begin
			blk_wr[pos[5:2]][{pos[1:0], 3'b000} +: 8] = data_byte;
		end
	end

	// Padded block: bytes before the mark kept, the mark, zeros, and the length if it fits.
	always_comb begin
		logic [511:0] flat;
		logic [511:0] padded;
		flat   = buf_q;
		padded = '0;
		for (int j = 0; j < 64; j++) begin
			if (6'(j) < pos) begin
				padded[j*8 +: 8] = flat[j*8 +: 8];
			end else if (6'(j) == pos) begin
				padded[j*8 +: 8] = md5_pkg::MD5_PAD_MARK;
			end
		end
		pad_blk = padded;
		if (pad_fits) begin
			pad_blk[14] = count_q[31:0];
			pad_blk[15] = count_q[63:32];
		end
	end

	// Extra block holding only the length.
	always_comb begin
		len_blk     = '0;
		len_blk[14] = count_q[31:0];
		len_blk[15] = count_q[63:32];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			md5_pkg::F_COLLECT: begin
				if (acc && last) begin
					state_d = md5_pkg::F_PAD;
				end
			end
			md5_pkg::F_PAD: begin
				if (!q_full) begin
					state_d = pad_fits ? md5_pkg::F_COLLECT : md5_pkg::F_LEN;
				end
			end
			md5_pkg::F_LEN: begin
				if (!q_full) begin
					state_d = md5_pkg::F_COLLECT;
				end
			end
			default: state_d = md5_pkg::F_COLLECT;
		endcase
	end

	// Outputs toward the input side and the block queue.
	always_comb begin
		full           = 1'b1;
		q_push         = 1'b0;
		q_blk.last_blk = 1'b0;
		q_blk.words    = blk_wr;
		cnt_clr        = 1'b0;
		unique case (state_q)
			md5_pkg::F_COLLECT: begin
				full   = q_full;
				q_push = push && !q_full && byte_valid && (pos == md5_pkg::MD5_LAST_POS);
			end
			md5_pkg::F_PAD: begin
				q_push         = !q_full;
				q_blk.last_blk = pad_fits;
				q_blk.words    = pad_blk;
				cnt_clr        = !q_full && pad_fits;
			end
			md5_pkg::F_LEN: begin
				q_push         = !q_full;
				q_blk.last_blk = 1'b1;
				q_blk.words    = len_blk;
				cnt_clr        = !q_full;
			end
			default: begin
				full = 1'b1;
			end
		endcase
	end

	// Sequencer state and message bit count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= md5_pkg::F_COLLECT;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (cnt_clr) begin
				count_q <= '0;
			end else if (acc && byte_valid) begin
				count_q <= count_q + 64'd8;
			end
		end
	end

	// Packing buffer.
	always_ff @(posedge clk) begin
		if (acc && byte_valid) begin
			buf_q <= blk_wr;
		end
	end

endmodule

`default_nettype wire

/* design/md5_blkq.sv */
`default_nettype none

module md5_blkq (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire md5_pkg::md5_blk_t push_blk,
	output logic              full,
	input  wire logic         pop,
	output md5_pkg::md5_blk_t head,
	output logic              empty
);

	// Two entries: one holds the block under compression while the other takes the next block.
	md5_pkg::md5_blk_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Block storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_blk;
		end
	end

endmodule

`default_nettype wire

/* design/md5_back.sv */
`default_nettype none
`include "md5_message_digest_defines.svh"

module md5_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire md5_pkg::md5_blk_t head,
	input  wire logic         q_empty,
	output logic              q_pop,
	output logic [31:0]       digest_word,
	output logic [1:0]        word_index,
	output logic              last_word,
	output logic              empty,
	input  wire logic         pop
);

	md5_pkg::md5_back_state_t state_q, state_d;
	logic [31:0] chain_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] mk_q;
	logic [5:0]  rnd_q;
	logic [31:0] dig_q [4];
	logic [2:0]  out_cnt_q;
	logic [1:0]  out_idx_q;

	logic [1:0]  grp;
	logic [31:0] sum1;
	logic [31:0] nb;
	logic [5:0]  mk_rnd;
	logic [31:0] mk_d;
	logic        adv;
	logic        out_pop;

	// One round: new b from a, the round function, constant plus message word, and rotation.
	assign grp  = rnd_q[5:4];
	assign sum1 = a_q + md5_pkg::md5_f(grp, b_q, c_q, d_q) + mk_q;
	assign nb   = b_q + md5_pkg::md5_rotl(sum1, md5_pkg::MD5_S[{grp, rnd_q[1:0]}]);

	// Constant plus message word for the coming round, registered ahead of its use.
	assign mk_rnd = (state_q == md5_pkg::B_LOAD) ? rnd_q : rnd_q + 6'd1;
	assign mk_d   = md5_pkg::MD5_K[mk_rnd] + head.words[md5_pkg::md5_msg_idx(mk_rnd)];

	// A final block waits until the previous digest has been read out.
	assign adv     = (state_q == md5_pkg::B_ADD) && !(head.last_blk && (out_cnt_q != 3'd0));
	assign out_pop = pop && !empty;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			md5_pkg::B_IDLE:  if (!q_empty) state_d = md5_pkg::B_LOAD;
			md5_pkg::B_LOAD:  state_d = md5_pkg::B_ROUND;
			md5_pkg::B_ROUND: if (rnd_q == 6'd63) state_d = md5_pkg::B_ADD;
			md5_pkg::B_ADD:   if (adv) state_d = md5_pkg::B_IDLE;
			default:          state_d = md5_pkg::B_IDLE;
		endcase
	end

	// Outputs: queue pop and the digest read port.
	always_comb begin
		q_pop       = adv;
		empty       = out_cnt_q == 3'd0;
		digest_word = dig_q[out_idx_q];
		word_index  = out_idx_q;
		last_word   = out_idx_q == 2'd3;
	end

	// Round datapath, chaining words and digest read-out control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= md5_pkg::B_IDLE;
			chain_q[0] <= md5_pkg::MD5_INIT_A;
			chain_q[1] <= md5_pkg::MD5_INIT_B;
			chain_q[2] <= md5_pkg::MD5_INIT_C;
			chain_q[3] <= md5_pkg::MD5_INIT_D;
			a_q        <= '0;
			b_q        <= '0;
			c_q        <= '0;
			d_q        <= '0;
			rnd_q      <= '0;
			out_cnt_q  <= '0;
			out_idx_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == md5_pkg::B_LOAD) begin
				a_q <= chain_q[0];
				b_q <= chain_q[1];
				c_q <= chain_q[2];
				d_q <= chain_q[3];
			end else if (state_q == md5_pkg::B_ROUND) begin
				a_q   <= d_q;
				b_q   <= nb;
				c_q   <= b_q;
				d_q   <= c_q;
				rnd_q <= rnd_q + 6'd1;
			end
			if (adv) begin
				if (head.last_blk) begin
					chain_q[0] <= md5_pkg::MD5_INIT_A;
					chain_q[1] <= md5_pkg::MD5_INIT_B;
					chain_q[2] <= md5_pkg::MD5_INIT_C;
					chain_q[3] <= md5_pkg::MD5_INIT_D;
				end else begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
				end
			end
			// A read-out transaction can coincide with the end of a non-final block.
			if (adv && head.last_blk) begin
				out_cnt_q <= 3'd4;
				out_idx_q <= 2'd0;
			end else if (out_pop) begin
				out_cnt_q <= out_cnt_q - 3'd1;
				out_idx_q <= out_idx_q + 2'd1;
			end
		end
	end

	// Prepared round input and digest words.
	always_ff @(posedge clk) begin
		if ((state_q == md5_pkg::B_LOAD) || (state_q == md5_pkg::B_ROUND)) begin
			mk_q <= mk_d;
		end
		if (adv && head.last_blk) begin
			dig_q[0] <= chain_q[0] + a_q;
			dig_q[1] <= chain_q[1] + b_q;
			dig_q[2] <= chain_q[2] + c_q;
			dig_q[3] <= chain_q[3] + d_q;
		end
	end

	// The round counter rests at zero between blocks.
	`MD5_ASSERT_IMPL(a_rnd_rest, state_q != md5_pkg::B_ROUND, rnd_q == 6'd0)
	// A block leaves the queue only when one is there.
	`MD5_ASSERT_IMPL(a_pop_held, q_pop, !q_empty)
	// After a final block the chain restarts and four digest words wait.
	`MD5_ASSERT_NEXT(a_final_load, adv && head.last_blk,
		chain_q[0] == md5_pkg::MD5_INIT_A && out_cnt_q == 3'd4)
	// A drained digest leaves the read index back at word A.
	`MD5_ASSERT_IMPL(a_idx_wrap, out_cnt_q == 3'd0, out_idx_q == 2'd0)

endmodule

`default_nettype wire

/* design/md5_message_digest.sv */
// Bytes are taken one per cycle while the two-entry block queue has room and the front is
// not writing padding. Each 64-byte block passes through the single round unit in order
// (load, 64 rounds, add, idle); the queue lets the next block be packed meanwhile.
// After the last item the front writes a padding block, plus a length-only block when the
// length does not fit; the first digest word shows once the final block has been added.
// Asynchronous active-low reset restores the initial chaining words and clears all control.
`default_nettype none

module md5_message_digest (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_valid,
	input  wire logic        last,
	input  wire logic        push,
	output logic             full,
	output logic [31:0]      digest_word,
	output logic [1:0]       word_index,
	output logic             last_word,
	output logic             empty,
	input  wire logic        pop
);

	md5_pkg::md5_blk_t wr_blk;
	md5_pkg::md5_blk_t head_blk;
	logic              q_push;
	logic              q_full;
	logic              q_pop;
	logic              q_empty;

	// Byte packing and padding.
	md5_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.last       (last),
		.push       (push),
		.full       (full),
		.q_push     (q_push),
		.q_blk      (wr_blk),
		.q_full     (q_full)
	);

	// Block queue between packing and the round unit.
	md5_blkq u_blkq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_blk (wr_blk),
		.full     (q_full),
		.pop      (q_pop),
		.head     (head_blk),
		.empty    (q_empty)
	);

	// Round unit and digest read-out.
	md5_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head_blk),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word),
		.empty       (empty),
		.pop         (pop)
	);

endmodule

`default_nettype wire
